@@ rtl/line_edit_input_buffer_assert.svh @@
// Assertion macros used by the port-level checker.
`ifndef LINE_EDIT_INPUT_BUFFER_ASSERT_SVH
`define LINE_EDIT_INPUT_BUFFER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define LEIB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define LEIB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/leib_pkg.sv @@
// Shared constants, types and pointer helpers of the line edit input buffer.
`default_nettype none
package leib_pkg;

	localparam int BUF_DEPTH = 128;
	localparam int IDX_W     = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam int LIN_W     = IDX_W + 1;

	localparam logic [7:0] KEY_PROC = 8'h10;
	localparam logic [7:0] KEY_KILL = 8'h15;
	localparam logic [7:0] KEY_BS   = 8'h08;
	localparam logic [7:0] KEY_DEL  = 8'h7F;
	localparam logic [7:0] KEY_EOF  = 8'h04;
	localparam logic [7:0] KEY_CR   = 8'h0D;
	localparam logic [7:0] KEY_LF   = 8'h0A;
	localparam logic [7:0] KEY_NUL  = 8'h00;

	localparam logic OP_TYPE = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [LIN_W:0]   DEPTH_L    = (LIN_W+1)'(BUF_DEPTH);
	localparam logic [LIN_W:0]   TWO_DEPTH  = (LIN_W+1)'(2 * BUF_DEPTH);
	localparam logic [LIN_W-1:0] DEPTH_DIST = LIN_W'(BUF_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(BUF_DEPTH - 1);

	// Ring pointer: lap bit plus store index, runs modulo twice the depth.
	typedef struct packed {
		logic             wrap;
		logic [IDX_W-1:0] idx;
	} ptr_t;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	typedef struct packed {
		logic accept;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_read;
	} dp_status_t;

	function automatic ptr_t ptr_inc(ptr_t p);
		ptr_t r;
		r = p;
		if (p.idx == LAST_IDX) begin
			r.idx  = '0;
			r.wrap = ~p.wrap;
		end else begin
			r.idx = p.idx + IDX_W'(1);
		end
		return r;
	endfunction

	function automatic ptr_t ptr_dec(ptr_t p);
		ptr_t r;
		r = p;
		if (p.idx == '0) begin
			r.idx  = LAST_IDX;
			r.wrap = ~p.wrap;
		end else begin
			r.idx = p.idx - IDX_W'(1);
		end
		return r;
	endfunction

	// Distance a - b modulo twice the depth.
	function automatic logic [LIN_W-1:0] ptr_dist(ptr_t a, ptr_t b);
		logic [LIN_W:0] la;
		logic [LIN_W:0] lb;
		logic [LIN_W:0] d;
		la = a.wrap ? DEPTH_L + (LIN_W+1)'(a.idx) : (LIN_W+1)'(a.idx);
		lb = b.wrap ? DEPTH_L + (LIN_W+1)'(b.idx) : (LIN_W+1)'(b.idx);
		if (la >= lb) begin
			d = la - lb;
		end else begin
			d = la + TWO_DEPTH - lb;
		end
		return d[LIN_W-1:0];
	endfunction

	// Counts are reported modulo 256.
	function automatic logic [7:0] to_byte(logic [LIN_W-1:0] v);
		logic [LIN_W+7:0] w;
		w = {8'd0, v};
		return w[7:0];
	endfunction

endpackage
`default_nettype wire

@@ rtl/leib_ifs.sv @@
// Valid/ready channel interfaces for input items and result items.
`default_nettype none
interface leib_in_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] typed_char;

	modport source (output valid, output opcode, output typed_char, input ready);
	modport sink (input valid, input opcode, input typed_char, output ready);
endinterface

interface leib_out_if;
	logic       valid;
	logic       ready;
	logic       echo_valid;
	logic [7:0] echo_char;
	logic [7:0] erase_count;
	logic       proc_list_request;
	logic       read_valid;
	logic [7:0] read_char;
	logic       line_end;
	logic [7:0] readable_count;

	modport source (output valid, output echo_valid, output echo_char, output erase_count,
		output proc_list_request, output read_valid, output read_char, output line_end,
		output readable_count, input ready);
	modport sink (input valid, input echo_valid, input echo_char, input erase_count,
		input proc_list_request, input read_valid, input read_char, input line_end,
		input readable_count, output ready);
endinterface
`default_nettype wire

@@ rtl/leib_ctrl.sv @@
// Controller: input acceptance, read wait state and output valid register.
`default_nettype none
module leib_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	input  wire leib_pkg::dp_status_t   status,
	output leib_pkg::ctrl_cmd_t         cmd
);

	leib_pkg::state_t state_q;
	leib_pkg::state_t state_d;
	logic             out_valid_q;
	logic             out_valid_d;
	logic             slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= leib_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		slot_free   = !out_valid_q || out_ready;
		in_ready    = 1'b0;
		cmd.accept  = 1'b0;
		state_d     = state_q;
		out_valid_d = out_valid_q && !out_ready;
		case (state_q)
			leib_pkg::ST_IDLE: begin
				in_ready   = slot_free;
				cmd.accept = in_valid && slot_free;
				if (cmd.accept) begin
					// store read port is registered: read results pass through the read wait state
					if (status.is_read) begin
						state_d = leib_pkg::ST_READ;
					end else begin
						out_valid_d = 1'b1;
					end
				end
			end
			leib_pkg::ST_READ: begin
				out_valid_d = 1'b1;
				state_d     = leib_pkg::ST_IDLE;
			end
			default: begin
				state_d = leib_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

@@ rtl/leib_dp.sv @@
// Datapath: ring pointers, line store, mode register and result registers.
`default_nettype none
module leib_dp (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_wdata,
	input  wire leib_pkg::ctrl_cmd_t  cmd,
	output leib_pkg::dp_status_t      status,
	input  wire logic                 opcode,
	input  wire logic [7:0]           typed_char,
	output logic                      echo_valid,
	output logic [7:0]                echo_char,
	output logic [7:0]                erase_count,
	output logic                      proc_list_request,
	output logic                      read_valid,
	output logic [7:0]                read_char,
	output logic                      line_end,
	output logic [7:0]                readable_count
);

	logic [7:0] mem [leib_pkg::BUF_DEPTH];
	logic [7:0] rdata_q;

	leib_pkg::ptr_t rd_q, cm_q, ed_q;
	leib_pkg::ptr_t rd_d, cm_d, ed_d;
	logic           raw_q;

	logic       echo_valid_q, plist_q, rvalid_q;
	logic [7:0] echo_char_q, erase_q, readable_q;

	logic       echo_v_d, plist_d, rvalid_d;
	logic [7:0] echo_c_d, erase_d;
	logic       we, re;
	logic [7:0] ch;
	logic       has_room;
	leib_pkg::ptr_t ed_inc;

	assign status.is_read = (opcode == leib_pkg::OP_READ);

	always_comb begin
		rd_d     = rd_q;
		cm_d     = cm_q;
		ed_d     = ed_q;
		echo_v_d = 1'b0;
		echo_c_d = 8'd0;
		erase_d  = 8'd0;
		plist_d  = 1'b0;
		rvalid_d = 1'b0;
		we       = 1'b0;
		re       = 1'b0;
		ed_inc   = leib_pkg::ptr_inc(ed_q);
		has_room = leib_pkg::ptr_dist(ed_q, rd_q) < leib_pkg::DEPTH_DIST;
		ch       = (typed_char == leib_pkg::KEY_CR) ? leib_pkg::KEY_LF : typed_char;
		if (opcode == leib_pkg::OP_READ) begin
			if (rd_q != cm_q) begin
				re       = 1'b1;
				rvalid_d = 1'b1;
				rd_d     = leib_pkg::ptr_inc(rd_q);
			end
		end else if (raw_q) begin
			if (ch != leib_pkg::KEY_NUL) begin
				echo_v_d = 1'b1;
				echo_c_d = ch;
				if (has_room) begin
					we   = 1'b1;
					ed_d = ed_inc;
					cm_d = ed_inc;
				end
			end
		end else if (typed_char == leib_pkg::KEY_PROC) begin
			plist_d = 1'b1;
		end else if (typed_char == leib_pkg::KEY_KILL) begin
			// uncommitted region never holds LF: kill the whole of it
			erase_d = leib_pkg::to_byte(leib_pkg::ptr_dist(ed_q, cm_q));
			ed_d    = cm_q;
		end else if (typed_char == leib_pkg::KEY_BS || typed_char == leib_pkg::KEY_DEL) begin
			if (ed_q != cm_q) begin
				ed_d    = leib_pkg::ptr_dec(ed_q);
				erase_d = 8'd1;
			end
		end else if (typed_char != leib_pkg::KEY_NUL && has_room) begin
			echo_v_d = 1'b1;
			echo_c_d = ch;
			we       = 1'b1;
			ed_d     = ed_inc;
			if (ch == leib_pkg::KEY_LF || ch == leib_pkg::KEY_EOF ||
				leib_pkg::ptr_dist(ed_inc, rd_q) == leib_pkg::DEPTH_DIST) begin
				cm_d = ed_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			cm_q  <= '0;
			ed_q  <= '0;
			raw_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				raw_q <= cfg_wdata;
			end
			if (cmd.accept) begin
				rd_q <= rd_d;
				cm_q <= cm_d;
				ed_q <= ed_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			echo_valid_q <= echo_v_d;
			echo_char_q  <= echo_c_d;
			erase_q      <= erase_d;
			plist_q      <= plist_d;
			rvalid_q     <= rvalid_d;
			readable_q   <= leib_pkg::to_byte(leib_pkg::ptr_dist(cm_d, rd_d));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && we) begin
			mem[ed_q.idx] <= ch;
		end
		if (cmd.accept && re) begin
			rdata_q <= mem[rd_q.idx];
		end
	end

	assign echo_valid        = echo_valid_q;
	assign echo_char         = echo_char_q;
	assign erase_count       = erase_q;
	assign proc_list_request = plist_q;
	assign read_valid        = rvalid_q;
	assign read_char         = rvalid_q ? rdata_q : 8'd0;
	assign line_end          = rvalid_q && (rdata_q == leib_pkg::KEY_LF);
	assign readable_count    = readable_q;

endmodule
`default_nettype wire

@@ rtl/line_edit_input_buffer.sv @@
// Line edit input buffer: typed characters are edited into a ring, readers pop committed bytes.
// Input channel in_ch: opcode 0 brings a typed character, opcode 1 asks for one committed byte.
// Output channel out_ch: one result beat per input beat, in order (echo, erase count,
// process list flag, popped byte with line end flag, bytes still readable).
// cfg_we/cfg_wdata set raw mode (1: commit each non-NUL byte that fits); write only when idle.
// A typed-character result is valid the cycle after its input beat; a read result
// passes through the read wait state first, since the line store has a registered read port.
// Throughput: one typed character per cycle while out_ch.ready is high; no new input beat
// is taken in the read wait state of the controller, which sets the read rate.
// The result register lets the next input beat in at the edge where out_ch.ready takes
// the waiting result; while the receiver stalls, in_ch.ready stays low and the result holds.
// Reset (arst_n low) clears all ring pointers and raw mode and drops any pending result;
// the line store is not cleared, no entry is read before it is written.
`default_nettype none
module line_edit_input_buffer (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cfg_we,
	input  wire logic  cfg_wdata,
	leib_in_if.sink    in_ch,
	leib_out_if.source out_ch
);

	leib_pkg::ctrl_cmd_t  cmd;
	leib_pkg::dp_status_t status;

	leib_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	leib_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.cmd               (cmd),
		.status            (status),
		.opcode            (in_ch.opcode),
		.typed_char        (in_ch.typed_char),
		.echo_valid        (out_ch.echo_valid),
		.echo_char         (out_ch.echo_char),
		.erase_count       (out_ch.erase_count),
		.proc_list_request (out_ch.proc_list_request),
		.read_valid        (out_ch.read_valid),
		.read_char         (out_ch.read_char),
		.line_end          (out_ch.line_end),
		.readable_count    (out_ch.readable_count)
	);

endmodule
`default_nettype wire

@@ rtl/leib_chk.sv @@
// Port-level checker for the line edit input buffer, bound to the top level.
`default_nettype none
`include "line_edit_input_buffer_assert.svh"
module leib_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       in_opcode,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       echo_valid,
	input wire logic [7:0] echo_char,
	input wire logic [7:0] erase_count,
	input wire logic       read_valid,
	input wire logic [7:0] read_char,
	input wire logic       line_end
);

	`LEIB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(echo_char) && $stable(read_char), "result changed while stalled")
	`LEIB_ASSERT_NEXT(a_type_next, in_valid && in_ready && in_opcode == leib_pkg::OP_TYPE, out_valid, "typed beat result not valid next cycle")
	`LEIB_ASSERT_NEXT(a_read_wait, in_valid && in_ready && in_opcode == leib_pkg::OP_READ, !out_valid, "read beat result came too early")
	`LEIB_ASSERT_NOW(a_read_excl, out_valid && read_valid, !echo_valid && erase_count == 8'd0, "read result carries edit fields")
	`LEIB_ASSERT_NOW(a_no_read, out_valid && !read_valid, read_char == 8'd0 && !line_end, "popped byte shown without a pop")

endmodule

bind line_edit_input_buffer leib_chk u_leib_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.in_opcode   (in_ch.opcode),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.echo_valid  (out_ch.echo_valid),
	.echo_char   (out_ch.echo_char),
	.erase_count (out_ch.erase_count),
	.read_valid  (out_ch.read_valid),
	.read_char   (out_ch.read_char),
	.line_end    (out_ch.line_end)
);
`default_nettype wire
